// File: rtl/hpt_pkg.sv
package hpt_pkg;

  localparam int COORD_W  = 16;
  localparam int COEF_W   = 32;
  localparam int OUT_W    = 24;
  localparam int PROD_W   = COEF_W + COORD_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int CFG_W    = 64;
  localparam int IDX_W    = 3;
  localparam int W_SHIFT  = 14;
  // numerator bits that enter the divider as fresh dividend bits
  localparam int NLO_W    = 2;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW  = $clog2(FIFO_DEPTH);

  localparam logic [IDX_W-1:0] REG_H00_H01 = 3'd0;
  localparam logic [IDX_W-1:0] REG_H02_H10 = 3'd1;
  localparam logic [IDX_W-1:0] REG_H11_H12 = 3'd2;
  localparam logic [IDX_W-1:0] REG_H20_H21 = 3'd3;
  localparam logic [IDX_W-1:0] REG_H22     = 3'd4;

  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_W-1:0] x_in;
    logic signed [COORD_W-1:0] y_in;
    logic                      last_point;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] x_out;
    logic signed [OUT_W-1:0] y_out;
    logic                    div_by_zero;
    logic                    saturated;
    logic                    last_out;
  } out_item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] h00;
    logic signed [COEF_W-1:0] h01;
    logic signed [COEF_W-1:0] h02;
    logic signed [COEF_W-1:0] h10;
    logic signed [COEF_W-1:0] h11;
    logic signed [COEF_W-1:0] h12;
    logic signed [COEF_W-1:0] h20;
    logic signed [COEF_W-1:0] h21;
    logic signed [COEF_W-1:0] h22;
  } coef_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [ACC_W-1:0] nmag_x;
    logic [ACC_W-1:0] nmag_y;
    logic [ACC_W-1:0] dmag;
    logic             neg_x;
    logic             neg_y;
    logic             big_x;
    logic             big_y;
    logic             dz;
    logic             last;
  } job_t;

  // one divider pipeline stage
  typedef struct packed {
    logic [ACC_W-1:0] rx;
    logic [ACC_W-1:0] ry;
    logic [ACC_W-1:0] d;
    logic [NLO_W-1:0] nlo_x;
    logic [NLO_W-1:0] nlo_y;
    logic [OUT_W-1:0] qx;
    logic [OUT_W-1:0] qy;
    logic             neg_x;
    logic             neg_y;
    logic             big_x;
    logic             big_y;
    logic             dz;
    logic             last;
  } div_stage_t;

  typedef struct packed {
    logic [ACC_W-1:0] r;
    logic             qb;
  } div_step_t;

  // one restoring division step
  function automatic div_step_t div_step(input logic [ACC_W-1:0] r,
                                         input logic [ACC_W-1:0] d,
                                         input logic b);
    logic [ACC_W:0] t;
    div_step_t      res;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      res.r  = ACC_W'(t - {1'b0, d});
      res.qb = 1'b1;
    end else begin
      res.qb = 1'b0;
      res.r  = ACC_W'(t);
    end
    return res;
  endfunction

  // clamp an unsigned quotient magnitude with sign to the output range
  function automatic logic [OUT_W:0] clamp_q(input logic [OUT_W-1:0] q,
                                             input logic neg,
                                             input logic big);
    logic [OUT_W:0] res;
    if (neg) begin
      if (big || (q > OUT_MIN)) res = {1'b1, OUT_MIN};
      else res = {1'b0, OUT_W'(-q)};
    end else begin
      if (big || (q > OUT_MAX)) res = {1'b1, OUT_MAX};
      else res = {1'b0, q};
    end
    return res;
  endfunction

endpackage

// File: rtl/hpt_front.sv
module hpt_front import hpt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  coef_t    coef,
  output logic     push,
  output job_t     push_job,
  input  logic     fifo_full
);

  logic v1, v2, v3;
  logic adv1, adv2, adv3;

  logic signed [PROD_W-1:0] px0, px1, py0, py1, pw0, pw1;
  logic                     last1;
  logic signed [ACC_W-1:0]  nx, ny, w;
  logic                     last2;
  job_t                     job3;

  logic signed [ACC_W-1:0]  nx_sum, ny_sum, w_sum;
  logic signed [COEF_W+W_SHIFT-1:0] h22s;
  job_t                     job_next;

  // stall chain
  assign adv3     = !v3 || !fifo_full;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;
  assign push     = v3 && !fifo_full;
  assign push_job = job3;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  // stage 1: products
  always_ff @(posedge clk) begin
    if (adv1) begin
      px0   <= coef.h00 * in_item.x_in;
      px1   <= coef.h01 * in_item.y_in;
      py0   <= coef.h10 * in_item.x_in;
      py1   <= coef.h11 * in_item.y_in;
      pw0   <= coef.h20 * in_item.x_in;
      pw1   <= coef.h21 * in_item.y_in;
      last1 <= in_item.last_point;
    end
  end

  // stage 2: sums, h22 aligned to the perspective scale
  assign h22s   = $signed({coef.h22, {W_SHIFT{1'b0}}});
  assign nx_sum = ACC_W'(px0) + ACC_W'(px1) + ACC_W'(coef.h02);
  assign ny_sum = ACC_W'(py0) + ACC_W'(py1) + ACC_W'(coef.h12);
  assign w_sum  = ACC_W'(pw0) + ACC_W'(pw1) + ACC_W'(h22s);

  always_ff @(posedge clk) begin
    if (adv2) begin
      nx    <= nx_sum;
      ny    <= ny_sum;
      w     <= w_sum;
      last2 <= last1;
    end
  end

  // stage 3: magnitudes, signs, zero divisor and overflow detection
  always_comb begin
    job_next.nmag_x = nx[ACC_W-1] ? ACC_W'(-nx) : ACC_W'(nx);
    job_next.nmag_y = ny[ACC_W-1] ? ACC_W'(-ny) : ACC_W'(ny);
    job_next.dmag   = w[ACC_W-1]  ? ACC_W'(-w)  : ACC_W'(w);
    job_next.neg_x  = nx[ACC_W-1] ^ w[ACC_W-1];
    job_next.neg_y  = ny[ACC_W-1] ^ w[ACC_W-1];
    // quotient needs more than OUT_W bits when n >= 4*d
    job_next.big_x  = {{NLO_W{1'b0}}, job_next.nmag_x} >= {job_next.dmag, {NLO_W{1'b0}}};
    job_next.big_y  = {{NLO_W{1'b0}}, job_next.nmag_y} >= {job_next.dmag, {NLO_W{1'b0}}};
    job_next.dz     = (w == '0);
    job_next.last   = last2;
  end

  always_ff @(posedge clk) begin
    if (adv3) job3 <= job_next;
  end

endmodule

// File: rtl/hpt_fifo.sv
module hpt_fifo import hpt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t pop_job
);

  job_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_AW:0]   count;

  assign full    = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty   = (count == '0);
  assign pop_job = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_job;
  end

endmodule

// File: rtl/hpt_back.sv
module hpt_back import hpt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  output logic      pop,
  input  logic      fifo_empty,
  input  job_t      pop_job,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic       adv;
  logic       sv [OUT_W+1];
  div_stage_t st [OUT_W+1];
  logic [OUT_W:0] cx, cy;

  assign adv = !out_valid || out_ready;
  assign pop = adv && !fifo_empty;

  // divider entry
  always_ff @(posedge clk) begin
    if (rst) sv[0] <= 1'b0;
    else if (adv) sv[0] <= pop;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0].rx    <= ACC_W'(pop_job.nmag_x >> NLO_W);
      st[0].ry    <= ACC_W'(pop_job.nmag_y >> NLO_W);
      st[0].d     <= pop_job.dmag;
      st[0].nlo_x <= pop_job.nmag_x[NLO_W-1:0];
      st[0].nlo_y <= pop_job.nmag_y[NLO_W-1:0];
      st[0].qx    <= '0;
      st[0].qy    <= '0;
      st[0].neg_x <= pop_job.neg_x;
      st[0].neg_y <= pop_job.neg_y;
      st[0].big_x <= pop_job.big_x;
      st[0].big_y <= pop_job.big_y;
      st[0].dz    <= pop_job.dz;
      st[0].last  <= pop_job.last;
    end
  end

  // one quotient bit per stage, both coordinates side by side
  for (genvar i = 0; i < OUT_W; i++) begin : g_div
    logic      bx, by;
    div_step_t sx, sy;
    div_stage_t nxt;

    // low numerator bits first, then zeros
    if (i < NLO_W) begin : g_lo
      assign bx = st[i].nlo_x[NLO_W-1-i];
      assign by = st[i].nlo_y[NLO_W-1-i];
    end else begin : g_zero
      assign bx = 1'b0;
      assign by = 1'b0;
    end

    assign sx = div_step(st[i].rx, st[i].d, bx);
    assign sy = div_step(st[i].ry, st[i].d, by);

    always_comb begin
      nxt    = st[i];
      nxt.rx = sx.r;
      nxt.ry = sy.r;
      nxt.qx = {st[i].qx[OUT_W-2:0], sx.qb};
      nxt.qy = {st[i].qy[OUT_W-2:0], sy.qb};
    end

    always_ff @(posedge clk) begin
      if (rst) sv[i+1] <= 1'b0;
      else if (adv) sv[i+1] <= sv[i];
    end

    always_ff @(posedge clk) begin
      if (adv) st[i+1] <= nxt;
    end
  end

  // sign, saturation and zero divisor
  assign cx = clamp_q(st[OUT_W].qx, st[OUT_W].neg_x, st[OUT_W].big_x);
  assign cy = clamp_q(st[OUT_W].qy, st[OUT_W].neg_y, st[OUT_W].big_y);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= sv[OUT_W];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item.last_out    <= st[OUT_W].last;
      out_item.div_by_zero <= st[OUT_W].dz;
      if (st[OUT_W].dz) begin
        out_item.x_out     <= '0;
        out_item.y_out     <= '0;
        out_item.saturated <= 1'b0;
      end else begin
        out_item.x_out     <= $signed(cx[OUT_W-1:0]);
        out_item.y_out     <= $signed(cy[OUT_W-1:0]);
        out_item.saturated <= cx[OUT_W] | cy[OUT_W];
      end
    end
  end

endmodule

// File: rtl/homography_point_transform.sv
// path of an item from acceptance to result valid: the accepting edge loads front
// stage 1, then 2 more front stages, the queue, a divider entry register, 24 divider
// stages and the output register; the divider is a fully pipelined restoring one
// throughput: one item per cycle unless out_ready stalls the output, set by the divider
// reset (synchronous, active high) empties all stages and the queue and loads
// the identity matrix into the coefficient registers
module homography_point_transform import hpt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  coef_t coef;
  logic  push, fifo_full, fifo_empty, pop;
  job_t  push_job, pop_job;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef.h00 <= 32'sd65536;
      coef.h01 <= '0;
      coef.h02 <= '0;
      coef.h10 <= '0;
      coef.h11 <= 32'sd65536;
      coef.h12 <= '0;
      coef.h20 <= '0;
      coef.h21 <= '0;
      coef.h22 <= 32'sd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_H00_H01: begin
          coef.h00 <= cfg_data[31:0];
          coef.h01 <= cfg_data[63:32];
        end
        REG_H02_H10: begin
          coef.h02 <= cfg_data[31:0];
          coef.h10 <= cfg_data[63:32];
        end
        REG_H11_H12: begin
          coef.h11 <= cfg_data[31:0];
          coef.h12 <= cfg_data[63:32];
        end
        REG_H20_H21: begin
          coef.h20 <= cfg_data[31:0];
          coef.h21 <= cfg_data[63:32];
        end
        REG_H22: begin
          coef.h22 <= cfg_data[31:0];
        end
        default: begin
        end
      endcase
    end
  end

  hpt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .coef      (coef),
    .push      (push),
    .push_job  (push_job),
    .fifo_full (fifo_full)
  );

  hpt_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (fifo_full),
    .pop      (pop),
    .empty    (fifo_empty),
    .pop_job  (pop_job)
  );

  hpt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop        (pop),
    .fifo_empty (fifo_empty),
    .pop_job    (pop_job),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule

// File: verif/tb_homography_point_transform.sv
module tb_homography_point_transform;
  import hpt_pkg::*;

  // index that maps to no register
  localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_item;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_item;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  homography_point_transform dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // local copy of the matrix
  logic [63:0] m_a, m_b, m_c, m_p;
  logic [31:0] m_w;

  in_item_t  point_q[$];
  out_item_t proj_q[$];
  int        errors = 0;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        hold_cycles;
  logic      hold_req;
  logic      hold_done;
  logic      in_taken;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // scaled truncating divide with clamp to the output range
  function automatic logic signed [OUT_W-1:0] proj_div(input longint num, input longint den,
                                                      inout logic sat);
    logic [63:0]  n, d;
    logic [127:0] qf;
    logic         neg;
    n   = (num < 0) ? -num : num;
    d   = (den < 0) ? -den : den;
    neg = (num < 0) != (den < 0);
    qf  = ({64'd0, n} << 22) / {64'd0, d};
    if (neg) begin
      if (qf > 128'd8388608) begin
        sat = 1'b1;
        return OUT_MIN;
      end
      return OUT_W'(-qf);
    end
    if (qf > 128'd8388607) begin
      sat = 1'b1;
      return OUT_MAX;
    end
    return OUT_W'(qf);
  endfunction

  function automatic out_item_t project_point(input in_item_t p);
    longint    x, y, nx, ny, w;
    out_item_t r;
    logic      sat;
    x  = longint'(p.x_in);
    y  = longint'(p.y_in);
    nx = longint'($signed(m_a[31:0])) * x + longint'($signed(m_a[63:32])) * y
         + longint'($signed(m_b[31:0]));
    ny = longint'($signed(m_b[63:32])) * x + longint'($signed(m_c[31:0])) * y
         + longint'($signed(m_c[63:32]));
    w  = longint'($signed(m_p[31:0])) * x + longint'($signed(m_p[63:32])) * y
         + longint'($signed(m_w)) * 16384;
    sat = 1'b0;
    r   = '0;
    if (w == 0) begin
      r.div_by_zero = 1'b1;
    end else begin
      r.x_out = proj_div(nx, w, sat);
      r.y_out = proj_div(ny, w, sat);
    end
    r.saturated = sat;
    r.last_out  = p.last_point;
    return r;
  endfunction

  // input acceptance: predict at the accepting edge
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready)
        proj_q = {proj_q, project_point(in_item)};
    end
  end

  // driver: offer pending points
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_item  <= '0;
    end else begin
      if (in_taken) void'(point_q.pop_front());
      if ((!in_valid || in_taken) && point_q.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_item  <= point_q[0];
      end else if (in_taken) begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver ready with random stalls and one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      hold_cycles <= 0;
      hold_done   <= 1'b0;
      out_ready   <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_cycles <= 200;
      hold_done   <= 1'b1;
      out_ready   <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready   <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (proj_q.size() == 0) begin
        $error("result with nothing expected: %p", out_item);
        errors++;
      end else begin
        exp_r = proj_q.pop_front();
        if (out_item.x_out !== exp_r.x_out) begin
          $error("x_out expected %0d got %0d", exp_r.x_out, out_item.x_out);
          errors++;
        end
        if (out_item.y_out !== exp_r.y_out) begin
          $error("y_out expected %0d got %0d", exp_r.y_out, out_item.y_out);
          errors++;
        end
        if (out_item.div_by_zero !== exp_r.div_by_zero) begin
          $error("div_by_zero expected %0b got %0b", exp_r.div_by_zero,
                 out_item.div_by_zero);
          errors++;
        end
        if (out_item.saturated !== exp_r.saturated) begin
          $error("saturated expected %0b got %0b", exp_r.saturated, out_item.saturated);
          errors++;
        end
        if (out_item.last_out !== exp_r.last_out) begin
          $error("last_out expected %0b got %0b", exp_r.last_out, out_item.last_out);
          errors++;
        end
      end
    end
  end

  task automatic write_coef(input logic [IDX_W-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_H00_H01: m_a = val;
      REG_H02_H10: m_b = val;
      REG_H11_H12: m_c = val;
      REG_H20_H21: m_p = val;
      REG_H22:     m_w = val[31:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_point(input logic [15:0] x, input logic [15:0] y, input logic lst);
    in_item_t p;
    p.x_in       = x;
    p.y_in       = y;
    p.last_point = lst;
    point_q = {point_q, p};
  endtask

  // wait for the pipeline to drain fully
  task automatic drain;
    wait (point_q.size() == 0 && !in_valid && proj_q.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coef(input int shape);
    case (shape)
      0: return $urandom_range(3) == 0 ? 32'h0001_0000 : 32'h0;
      1: return 32'($signed($urandom_range(8191)) - 4096);
      2: return $urandom;
      default: return 32'($signed($urandom_range(262143)) - 131072);
    endcase
  endfunction

  task automatic rand_points(input int n, input int narrow);
    repeat (n) begin
      if (narrow)
        add_point(16'($signed($urandom_range(2047)) - 1024),
                  16'($signed($urandom_range(2047)) - 1024), $urandom_range(7) == 0);
      else
        add_point(16'($urandom), 16'($urandom), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    send_idle_pct = 34;
    recv_idle_pct = 66;
    hold_req      = 1'b0;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    m_a = 64'd65536; m_b = 64'd0; m_c = 64'd65536; m_p = 64'd0; m_w = 32'd65536;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // identity: field extremes pass through unsaturated
    add_point(16'h7fff, 16'h8000, 1'b0);
    add_point(16'h8000, 16'h7fff, 1'b1);
    add_point(16'h0000, 16'hffff, 1'b0);
    add_point(16'h5555, 16'haaaa, 1'b1);
    add_point(16'h0001, 16'h0000, 1'b0);
    drain();

    // zero divisor through h22 alone
    write_coef(REG_H22, 64'd0);
    add_point(16'd0, 16'd0, 1'b1);
    add_point(16'd5, 16'hfffb, 1'b0);
    drain();

    // perspective terms that cancel at chosen points
    write_coef(REG_H20_H21, {32'h4000_0000, 32'hc000_0000});
    write_coef(REG_H22, 64'h0001_0000);
    add_point(16'd1, 16'd0, 1'b0);
    add_point(16'd3, 16'd3, 1'b0);
    add_point(16'd0, 16'hffff, 1'b1);
    add_point(16'h7fff, 16'h7fff, 1'b0);
    drain();

    // extreme coefficients, tiny divisor: saturation both signs
    write_coef(REG_H00_H01, {32'h8000_0000, 32'h7fff_ffff});
    write_coef(REG_H02_H10, {32'h7fff_ffff, 32'h8000_0000});
    write_coef(REG_H11_H12, {32'h8000_0000, 32'hffff_ffff});
    write_coef(REG_H20_H21, 64'd0);
    write_coef(REG_H22, 64'h0000_0001);
    add_point(16'h7fff, 16'h8000, 1'b0);
    add_point(16'h8000, 16'h8000, 1'b1);
    add_point(16'd0, 16'd0, 1'b0);
    drain();
    write_coef(REG_H22, 64'h8000_0000);
    add_point(16'h7fff, 16'h7fff, 1'b0);
    add_point(16'h8000, 16'h0001, 1'b1);
    drain();
    write_coef(REG_NONE, 64'hdead_beef_dead_beef);
    add_point(16'd9, 16'd9, 1'b0);
    drain();

    // random phases: each new matrix, mostly well-conditioned
    for (int ph = 0; ph < 24; ph++) begin
      int shp;
      if (ph == 8)  begin send_idle_pct = 66; recv_idle_pct = 34; end
      if (ph == 16) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      shp = ph % 4;
      write_coef(REG_H00_H01, {rand_coef(shp), (shp == 0) ? 32'h0001_0000 : rand_coef(shp)});
      write_coef(REG_H02_H10, {rand_coef(shp), $urandom});
      write_coef(REG_H11_H12, {$urandom, rand_coef(shp)});
      write_coef(REG_H20_H21, (shp == 2) ? {$urandom, $urandom} :
                 {32'($signed($urandom_range(2047)) - 1024),
                  32'($signed($urandom_range(2047)) - 1024)});
      write_coef(REG_H22, (ph % 6 == 5) ? 64'd0 : {32'd0, rand_coef(shp == 0 ? 3 : shp)});
      if (ph == 20) hold_req = 1'b1;
      rand_points(34, ph % 3 != 2);
      drain();
    end

    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: sim.f
rtl/hpt_pkg.sv
rtl/hpt_front.sv
rtl/hpt_fifo.sv
rtl/hpt_back.sv
rtl/homography_point_transform.sv
verif/tb_homography_point_transform.sv
